FILE: src/stphs_pkg.sv
// ----------------------------------------------------------------------------
// stphs_pkg
// Types, constants and the coil table of the half-step stepper driver.
// ----------------------------------------------------------------------------
package stphs_pkg;

	localparam int REVS_AVERAGED = 3;
	localparam int HALF_STEPS    = 8;
	localparam int IDX_W         = $clog2(HALF_STEPS);
	localparam int PHASE_W       = $clog2(REVS_AVERAGED + 1);
	localparam int REM_W         = (REVS_AVERAGED > 1) ? $clog2(REVS_AVERAGED) : 1;
	localparam int COUNT_W       = 20;
	localparam int SPR_W         = 16;
	localparam int EIGHTHS_W     = 16;
	localparam int PROD_W        = EIGHTHS_W + SPR_W;
	localparam int STEPS_W       = PROD_W - IDX_W;
	localparam int COIL_W        = 4;
	localparam int IN_DATA_W     = 24;
	localparam int OUT_DATA_W    = 32;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_CALIB = 2'd1,
		ACT_RUN   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNCAL = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CALIB = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	// clockwise half-step sequence, bit0 coil A to bit3 coil D
	function automatic logic [COIL_W-1:0] coil_lookup(input logic [IDX_W-1:0] idx);
		logic [COIL_W-1:0] pat;
		case (idx)
			3'd0:    pat = 4'h1;
			3'd1:    pat = 4'h3;
			3'd2:    pat = 4'h2;
			3'd3:    pat = 4'h6;
			3'd4:    pat = 4'h4;
			3'd5:    pat = 4'hC;
			3'd6:    pat = 4'h8;
			3'd7:    pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

FILE: src/stepper_half_step_calibrating_driver.sv
// ----------------------------------------------------------------------------
// stepper_half_step_calibrating_driver
// Half-step sequencer for a four-coil stepper with opto-sensor calibration.
// The input register holds each accepted word; the result register then
// holds its result. Throughput: one word per cycle while m_tready holds;
// while a result waits, input is taken only if the input register is empty.
// The run length multiply is a single 16x16 product in the input stage.
// Reset: arst_n clears all control and motor state; no clearing pass.
// ----------------------------------------------------------------------------
module stepper_half_step_calibrating_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sensor_level[0], run_eighths[16:1], zero fill
	input  logic [stphs_pkg::IN_DATA_W-1:0]    s_tdata,
	// action[1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// coil_pattern[3:0], coil_update[4], busy_res[5], calibrated[6],
	// steps_per_rev_out[22:7], status[24:23], zero fill
	output logic [stphs_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int IW = stphs_pkg::IDX_W;
	localparam int PW = stphs_pkg::PHASE_W;
	localparam int RW = stphs_pkg::REM_W;
	localparam int CW = stphs_pkg::COUNT_W;
	localparam int SW = stphs_pkg::SPR_W;
	localparam int EW = stphs_pkg::EIGHTHS_W;
	localparam int LW = stphs_pkg::STEPS_W;
	localparam int KW = stphs_pkg::COIL_W;

	// input stage
	logic                   valid_s1;
	stphs_pkg::action_t     act_s1;
	logic                   sensor_s1;
	logic [EW-1:0]          eighths_s1;

	// result stage
	logic                   out_valid_q;
	logic [KW-1:0]          pattern_q;
	logic                   update_q;
	logic                   busy_q;
	logic                   cal_out_q;
	logic [SW-1:0]          spr_out_q;
	stphs_pkg::status_t     status_q;

	// block state
	stphs_pkg::mode_t       mode_q, mode_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [PW-1:0]          phase_q, phase_d;
	logic                   last_q, last_d;
	logic                   cur_q, cur_d;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          quot_q, quot_d;
	logic [RW-1:0]          rem_q, rem_d;
	logic [SW-1:0]          spr_q, spr_d;
	logic                   cal_q, cal_d;
	logic [LW-1:0]          left_q, left_d;

	logic                   advance;
	logic [KW-1:0]          pattern_d;
	logic                   update_d;
	stphs_pkg::status_t     status_d;
	logic [stphs_pkg::PROD_W-1:0] prod;
	logic [LW-1:0]          run_steps;
	logic [LW-1:0]          left_dec;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	assign prod      = {{SW{1'b0}}, eighths_s1} * {{EW{1'b0}}, spr_q};
	assign run_steps = prod[stphs_pkg::PROD_W-1:IW];
	assign left_dec  = left_q - LW'(left_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1     <= stphs_pkg::action_t'(s_tuser);
			sensor_s1  <= s_tdata[0];
			eighths_s1 <= s_tdata[EW:1];
		end
	end

	always_comb begin
		mode_d    = mode_q;
		idx_d     = idx_q;
		phase_d   = phase_q;
		last_d    = last_q;
		cur_d     = cur_q;
		count_d   = count_q;
		quot_d    = quot_q;
		rem_d     = rem_q;
		spr_d     = spr_q;
		cal_d     = cal_q;
		left_d    = left_q;
		pattern_d = '0;
		update_d  = 1'b0;
		status_d  = stphs_pkg::ST_OK;
		case (act_s1)
			stphs_pkg::ACT_CALIB, stphs_pkg::ACT_RUN: begin
				if (mode_q != stphs_pkg::MODE_IDLE) begin
					status_d = stphs_pkg::ST_BUSY;
				end else if (act_s1 == stphs_pkg::ACT_CALIB) begin
					mode_d  = stphs_pkg::MODE_CALIB;
					last_d  = 1'b0;
					cur_d   = sensor_s1;
					phase_d = '0;
					count_d = '0;
					quot_d  = '0;
					rem_d   = '0;
				end else if (spr_q == '0) begin
					status_d = stphs_pkg::ST_UNCAL;
				end else begin
					left_d = run_steps;
					if (run_steps != '0) begin
						mode_d = stphs_pkg::MODE_RUN;
					end
				end
			end
			stphs_pkg::ACT_TICK: begin
				if (mode_q == stphs_pkg::MODE_CALIB) begin
					last_d = cur_q;
					cur_d  = sensor_s1;
					if (last_q && !cur_q) begin
						if (phase_q >= PW'(stphs_pkg::REVS_AVERAGED)) begin
							spr_d  = (quot_q[CW-1:SW] != '0) ? {SW{1'b1}} : quot_q[SW-1:0];
							cal_d  = 1'b1;
							mode_d = stphs_pkg::MODE_IDLE;
						end else begin
							phase_d = phase_q + PW'(1);
						end
					end else begin
						pattern_d = stphs_pkg::coil_lookup(idx_q);
						update_d  = 1'b1;
						idx_d     = idx_q + IW'(1);
						if (phase_q != '0 && count_q != {CW{1'b1}}) begin
							count_d = count_q + CW'(1);
							// running quotient of the count by the averaging factor
							if (rem_q == RW'(stphs_pkg::REVS_AVERAGED - 1)) begin
								rem_d  = '0;
								quot_d = quot_q + CW'(1);
							end else begin
								rem_d = rem_q + RW'(1);
							end
						end
					end
				end else if (mode_q == stphs_pkg::MODE_RUN) begin
					pattern_d = stphs_pkg::coil_lookup(idx_q);
					update_d  = 1'b1;
					idx_d     = idx_q + IW'(1);
					left_d    = left_dec;
					if (left_dec == '0) begin
						mode_d = stphs_pkg::MODE_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stphs_pkg::MODE_IDLE;
			idx_q   <= '0;
			phase_q <= '0;
			last_q  <= 1'b0;
			cur_q   <= 1'b0;
			count_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			spr_q   <= '0;
			cal_q   <= 1'b0;
			left_q  <= '0;
		end else if (valid_s1 && advance) begin
			mode_q  <= mode_d;
			idx_q   <= idx_d;
			phase_q <= phase_d;
			last_q  <= last_d;
			cur_q   <= cur_d;
			count_q <= count_d;
			quot_q  <= quot_d;
			rem_q   <= rem_d;
			spr_q   <= spr_d;
			cal_q   <= cal_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pattern_q <= pattern_d;
			update_q  <= update_d;
			busy_q    <= (mode_d != stphs_pkg::MODE_IDLE);
			cal_out_q <= cal_d;
			spr_out_q <= spr_d;
			status_q  <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, status_q, spr_out_q, cal_out_q, busy_q, update_q, pattern_q};

	// no coil drive unless a step is taken
	a_no_drive_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !update_q |-> pattern_q == '0)
		else $error("coil pattern without step");

	// a busy refusal leaves the block busy
	a_busy_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == stphs_pkg::ST_BUSY |-> busy_q)
		else $error("busy refusal while idle");

	// a run always has steps left
	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == stphs_pkg::MODE_RUN |-> left_q != '0)
		else $error("run with no steps left");

	// remainder stays below the averaging factor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= RW'(stphs_pkg::REVS_AVERAGED - 1))
		else $error("remainder out of range");

	// result register holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(status_q) && $stable(spr_out_q))
		else $error("result changed while stalled");

endmodule
